[design/cjs_pkg.sv]
// ----------------------------------------------------------------------------
// cjs_pkg
// Shared types and constants of the CPU job scheduler.
// ----------------------------------------------------------------------------
package cjs_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam logic [7:0]  SliceReset        = 8'd3;

  localparam logic [2:0] MODE_FCFS = 3'd0;
  localparam logic [2:0] MODE_SJN  = 3'd1;
  localparam logic [2:0] MODE_SRTF = 3'd2;
  localparam logic [2:0] MODE_PRIO = 3'd3;
  localparam logic [2:0] MODE_RR   = 3'd4;

  localparam logic [1:0] CPU_IDLE   = 2'd0;
  localparam logic [1:0] CPU_BUSY   = 2'd1;
  localparam logic [1:0] CPU_SWITCH = 2'd2;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_SLICE = 1'b1;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] left;
    logic [15:0] orig;
    logic [31:0] arr;
    logic [31:0] resp;
    logic        responded;
  } cjs_job_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  job_id;
    logic [7:0]  job_priority;
    logic [15:0] job_length;
  } cjs_in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  cpu_state;
    logic [7:0]  running_id;
    logic [15:0] running_left;
    logic        finished;
    logic [7:0]  finished_id;
    logic [31:0] turnaround;
    logic [31:0] wait_time;
    logic [31:0] response;
    logic [31:0] switch_count;
    logic [31:0] done_count;
    logic [31:0] now;
  } cjs_out_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SRD0  = 7'b0000010,
    ST_SLOAD = 7'b0000100,
    ST_SPASS = 7'b0001000,
    ST_SEND  = 7'b0010000,
    ST_HEAD  = 7'b0100000,
    ST_EXEC  = 7'b1000000
  } cjs_state_e;

endpackage

[design/cjs_ram.sv]
// ----------------------------------------------------------------------------
// cjs_ram
// Ready queue storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cjs_ram
  import cjs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  localparam int unsigned PW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [PW-1:0] waddr_i,
  input  cjs_job_t      wdata_i,
  input  logic [PW-1:0] raddr_i,
  output cjs_job_t      rdata_o
);

  cjs_job_t mem [QUEUE_DEPTH];
  cjs_job_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/cpu_job_scheduler.sv]
// ----------------------------------------------------------------------------
// cpu_job_scheduler
// Tick-driven single-CPU job scheduler (FCFS, SJN, SRTF, priority, RR).
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o   | cjs_in_t  in_data_i
//  out     | output    | out_valid_o/out_stall_i | cjs_out_t out_data_o
//  cfg     | input     | APB psel/penable/pwrite | sched_mode @0, time_slice @4
//
// Arrival: the result is registered at the accept edge.
// Tick: accept, head read, update; in modes SJN/SRTF/priority with two or
// more queued jobs, bubble passes over the queue RAM come between accept and
// head read, one pass per swap round plus a final clean pass.
// Reset clears all control state; the queue RAM holds no reset value, only
// counted entries are ever read. Input stalls while a tick is in work or an
// undelivered result is stalled downstream.
// ----------------------------------------------------------------------------
module cpu_job_scheduler
  import cjs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  cjs_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output cjs_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // config registers
  logic [2:0] mode_q;
  logic [7:0] slice_cfg_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SLICE) ? {24'd0, slice_cfg_q} : {29'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FCFS;
      slice_cfg_q <= SliceReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MODE) mode_q <= pwdata[2:0];
      else                      slice_cfg_q <= pwdata[7:0];
    end
  end

  // logical queue index -> RAM address (circular buffer)
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[PW-1:0];
  endfunction

  function automatic logic [15:0] sort_key(input logic [2:0] m, input cjs_job_t j);
    return (m == MODE_PRIO) ? {8'd0, j.prio} : j.left;
  endfunction

  cjs_state_e  state_q, state_d;
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ridx_q, ridx_d;
  logic          swapped_q, swapped_d;
  cjs_job_t      carry_q, carry_d;
  cjs_job_t      cur_q, cur_d;
  logic [1:0]    status_q, status_d;
  logic [7:0]    slice_q, slice_d;
  logic [31:0]   tick_q, tick_d;
  logic [31:0]   switches_q, switches_d;
  logic [31:0]   done_q, done_d;
  logic          out_valid_q, out_valid_d;
  cjs_out_t      out_q, out_d;

  logic          we;
  logic [PW-1:0] waddr, raddr;
  cjs_job_t      wdata, rdata;

  cjs_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic in_acc, sort_mode;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sort_mode  = (mode_q == MODE_SJN) || (mode_q == MODE_SRTF) || (mode_q == MODE_PRIO);

  // tick update terms
  logic [15:0] left_dec;
  logic [31:0] resp_n, ta;
  logic [7:0]  slice_dec;
  logic        preempt;

  always_comb begin
    left_dec  = (cur_q.left != 16'd0) ? cur_q.left - 16'd1 : 16'd0;
    resp_n    = cur_q.responded ? cur_q.resp : tick_q - cur_q.arr;
    slice_dec = (mode_q == MODE_RR && slice_q != 8'd0) ? slice_q - 8'd1 : slice_q;
    preempt   = 1'b0;
    if (left_dec != 16'd0) begin
      if (mode_q == MODE_RR) preempt = (slice_dec == 8'd0);
      else if (mode_q == MODE_SRTF) preempt = (count_q != '0) && (left_dec > rdata.left);
    end
    ta = tick_q - cur_q.arr;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    ridx_d      = ridx_q;
    swapped_d   = swapped_q;
    carry_d     = carry_q;
    cur_d       = cur_q;
    status_d    = status_q;
    slice_d     = slice_q;
    tick_d      = tick_q;
    switches_d  = switches_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = phys(head_q, count_q);
    wdata       = carry_q;
    raddr       = phys(head_q, ridx_q);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.opcode == OP_ARRIVAL) begin
            out_d = '0;
            if (count_q != CW'(QUEUE_DEPTH)) begin
              we              = 1'b1;
              wdata.id        = in_data_i.job_id;
              wdata.prio      = in_data_i.job_priority;
              wdata.left      = in_data_i.job_length;
              wdata.orig      = in_data_i.job_length;
              wdata.arr       = tick_q;
              wdata.resp      = 32'd0;
              wdata.responded = 1'b0;
              count_d         = count_q + CW'(1);
              out_d.accepted  = 1'b1;
            end
            out_d.cpu_state    = status_q;
            out_d.running_id   = (status_q == CPU_IDLE) ? 8'd0 : cur_q.id;
            out_d.running_left = (status_q == CPU_IDLE) ? 16'd0 : cur_q.left;
            out_d.switch_count = switches_q;
            out_d.done_count   = done_q;
            out_d.now          = tick_q;
            out_valid_d        = 1'b1;
          end else if (sort_mode && count_q > CW'(1)) begin
            state_d = ST_SRD0;
          end else begin
            state_d = ST_HEAD;
          end
        end
      end
      ST_SRD0: begin
        raddr     = phys(head_q, '0);
        ridx_d    = CW'(1);
        swapped_d = 1'b0;
        state_d   = ST_SLOAD;
      end
      ST_SLOAD: begin
        carry_d = rdata;
        raddr   = phys(head_q, ridx_q);
        ridx_d  = ridx_q + CW'(1);
        state_d = ST_SPASS;
      end
      ST_SPASS: begin
        // rdata is entry ridx-1; the smaller of carry/rdata lands at ridx-2
        we    = 1'b1;
        waddr = phys(head_q, ridx_q - CW'(2));
        if (sort_key(mode_q, carry_q) > sort_key(mode_q, rdata)) begin
          wdata     = rdata;
          swapped_d = 1'b1;
        end else begin
          wdata   = carry_q;
          carry_d = rdata;
        end
        if (ridx_q < count_q) begin
          raddr  = phys(head_q, ridx_q);
          ridx_d = ridx_q + CW'(1);
        end else begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        we      = 1'b1;
        waddr   = phys(head_q, count_q - CW'(1));
        wdata   = carry_q;
        state_d = swapped_q ? ST_SRD0 : ST_HEAD;
      end
      ST_HEAD: begin
        raddr   = phys(head_q, '0);
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        out_d = '0;
        if (status_q == CPU_BUSY) begin
          if (left_dec == 16'd0) begin
            done_d            = done_q + 32'd1;
            out_d.finished    = 1'b1;
            out_d.finished_id = cur_q.id;
            out_d.turnaround  = ta;
            out_d.wait_time   = ta - 32'(cur_q.orig);
            out_d.response    = resp_n;
            cur_d.left        = 16'd0;
            if (count_q == '0) begin
              status_d = CPU_IDLE;
            end else begin
              cur_d   = rdata;
              slice_d = slice_cfg_q;
              head_d  = phys(head_q, CW'(1));
              count_d = count_q - CW'(1);
            end
          end else begin
            cur_d.left      = left_dec;
            cur_d.resp      = resp_n;
            cur_d.responded = 1'b1;
            slice_d         = slice_dec;
            if (preempt) status_d = CPU_SWITCH;
          end
        end else if (status_q == CPU_IDLE) begin
          if (count_q != '0) begin
            cur_d    = rdata;
            slice_d  = slice_cfg_q;
            head_d   = phys(head_q, CW'(1));
            count_d  = count_q - CW'(1);
            status_d = CPU_BUSY;
          end
        end else begin
          switches_d = switches_q + 32'd1;
          if (count_q != '0) begin
            // held job goes to the back, head is taken
            we     = 1'b1;
            waddr  = phys(head_q, count_q);
            wdata  = cur_q;
            cur_d  = rdata;
            head_d = phys(head_q, CW'(1));
          end
          if (mode_q == MODE_RR) slice_d = slice_cfg_q;
          status_d = CPU_BUSY;
        end
        tick_d             = tick_q + 32'd1;
        out_d.cpu_state    = status_d;
        out_d.running_id   = (status_d == CPU_IDLE) ? 8'd0 : cur_d.id;
        out_d.running_left = (status_d == CPU_IDLE) ? 16'd0 : cur_d.left;
        out_d.switch_count = switches_d;
        out_d.done_count   = done_d;
        out_d.now          = tick_q;
        out_valid_d        = 1'b1;
        state_d            = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      ridx_q      <= '0;
      swapped_q   <= 1'b0;
      cur_q       <= '0;
      status_q    <= CPU_IDLE;
      slice_q     <= SliceReset;
      tick_q      <= '0;
      switches_q  <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      ridx_q      <= ridx_d;
      swapped_q   <= swapped_d;
      cur_q       <= cur_d;
      status_q    <= status_d;
      slice_q     <= slice_d;
      tick_q      <= tick_d;
      switches_q  <= switches_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // queue fill never passes its depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // a tick only reaches its update step with the result register free
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !out_valid_q)
    else $error("result register busy at tick update");

  // an arrival into a non-full queue grows it by one
  a_arrival_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.opcode == OP_ARRIVAL && count_q != CW'(QUEUE_DEPTH))
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("arrival did not enqueue");

endmodule

[bench/tb_cpu_job_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_cpu_job_scheduler
// Self-checking bench for the CPU job scheduler. A behavioral scheduler model
// predicts one result per transaction; a clocked driver and monitor run the
// valid/stall channels with random idle bursts, and phases sweep all modes and
// quantum settings through the APB port.
// ----------------------------------------------------------------------------
module tb_cpu_job_scheduler
  import cjs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  cjs_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  cjs_out_t    out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cpu_job_scheduler #(.QUEUE_DEPTH(Depth)) DUT (.*);

  // --------------------------------------------------------------------------
  // Scheduler model state
  // --------------------------------------------------------------------------
  cjs_job_t    run_q[$];
  cjs_job_t    cur_job;
  logic [1:0]  cpu_st;
  logic [7:0]  slice_cnt;
  logic [31:0] tick_no;
  logic [31:0] nswitch;
  logic [31:0] ndone;
  logic [2:0]  mode_reg;
  logic [7:0]  slice_reg;

  cjs_in_t     pending_q[$];   // transactions waiting for the driver
  cjs_out_t    expected_q[$];  // predicted results, oldest first
  int          n_errors;
  int          n_results;
  int          n_finished;
  bit          drive_quiet;    // disables sender idling
  bit          recv_quiet;     // disables receiver stalls
  bit          hold_recv;      // long receiver hold-off request

  function automatic logic [15:0] sort_key(cjs_job_t j);
    return (mode_reg == MODE_PRIO) ? 16'(j.prio) : j.left;
  endfunction

  // stable insertion sort, only in the sorting modes
  function automatic void reorder_queue();
    cjs_job_t tmp;
    int       k;
    if (mode_reg != MODE_SJN && mode_reg != MODE_SRTF && mode_reg != MODE_PRIO) return;
    for (int i = 1; i < run_q.size(); i++) begin
      tmp = run_q[i];
      k = i;
      while (k > 0 && sort_key(run_q[k-1]) > sort_key(tmp)) begin
        run_q[k] = run_q[k-1];
        k--;
      end
      run_q[k] = tmp;
    end
  endfunction

  function automatic cjs_out_t schedule_step(cjs_in_t it);
    cjs_out_t   r;
    cjs_job_t   nj;
    logic [31:0] ts;
    bit         pre;
    r = '0;
    ts = tick_no;
    if (it.opcode == OP_ARRIVAL) begin
      if (run_q.size() < Depth) begin
        nj = '0;
        nj.id = it.job_id;
        nj.prio = it.job_priority;
        nj.left = it.job_length;
        nj.orig = it.job_length;
        nj.arr = tick_no;
        run_q = {run_q, nj};
        r.accepted = 1'b1;
      end
    end else begin
      reorder_queue();
      if (cpu_st == CPU_BUSY) begin
        pre = 0;
        if (cur_job.left != 0) cur_job.left--;
        if (!cur_job.responded) begin
          cur_job.resp = ts - cur_job.arr;
          cur_job.responded = 1'b1;
        end
        if (mode_reg == MODE_RR && slice_cnt != 0) slice_cnt--;
        if (cur_job.left != 0) begin
          if (mode_reg == MODE_RR) pre = (slice_cnt == 0);
          else if (mode_reg == MODE_SRTF)
            pre = run_q.size() > 0 && cur_job.left > run_q[0].left;
        end
        if (cur_job.left == 0) begin
          ndone++;
          r.finished = 1'b1;
          r.finished_id = cur_job.id;
          r.turnaround = ts - cur_job.arr;
          r.wait_time = r.turnaround - 32'(cur_job.orig);
          r.response = cur_job.resp;
          if (run_q.size() == 0) cpu_st = CPU_IDLE;
          else begin
            cur_job = run_q.pop_front();
            slice_cnt = slice_reg;
          end
        end else if (pre) cpu_st = CPU_SWITCH;
      end else if (cpu_st == CPU_IDLE) begin
        if (run_q.size() > 0) begin
          cur_job = run_q.pop_front();
          slice_cnt = slice_reg;
          cpu_st = CPU_BUSY;
        end
      end else begin
        nswitch++;
        if (run_q.size() > 0) begin
          nj = run_q.pop_front();
          run_q = {run_q, cur_job};
          cur_job = nj;
        end
        if (mode_reg == MODE_RR) slice_cnt = slice_reg;
        cpu_st = CPU_BUSY;
      end
      tick_no++;
    end
    r.cpu_state = cpu_st;
    r.running_id = (cpu_st == CPU_IDLE) ? 8'd0 : cur_job.id;
    r.running_left = (cpu_st == CPU_IDLE) ? 16'd0 : cur_job.left;
    r.switch_count = nswitch;
    r.done_count = ndone;
    r.now = ts;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_cpu_job_scheduler failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: offers pending transactions, random idle bursts
  // --------------------------------------------------------------------------
  int drv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      drv_gap    = 0;
    end else begin
      // the transaction on the bus was taken at this edge
      if (in_valid_i && !in_stall_o) begin
        expected_q = {expected_q, schedule_step(in_data_i)};
        void'(pending_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (drv_gap > 0) drv_gap--;
        else if (!drive_quiet && $urandom_range(0, 9) == 0) drv_gap = int'($urandom_range(1, 10));
        if (drv_gap == 0 && pending_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compares results, drives random stall bursts
  // --------------------------------------------------------------------------
  int stall_cnt;
  task automatic compare_result(cjs_out_t got);
    cjs_out_t exp_r;
    if (expected_q.size() == 0) begin
      $error("unexpected result %p", got);
      n_errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    n_results++;
    if (exp_r.finished) n_finished++;
    if (got.accepted != exp_r.accepted) begin
      $error("accepted exp %0d got %0d", exp_r.accepted, got.accepted); n_errors++; end
    if (got.cpu_state != exp_r.cpu_state) begin
      $error("cpu_state exp %0d got %0d", exp_r.cpu_state, got.cpu_state); n_errors++; end
    if (got.running_id != exp_r.running_id) begin
      $error("running_id exp %0d got %0d", exp_r.running_id, got.running_id); n_errors++; end
    if (got.running_left != exp_r.running_left) begin
      $error("running_left exp %0d got %0d", exp_r.running_left, got.running_left);
      n_errors++;
    end
    if (got.finished != exp_r.finished) begin
      $error("finished exp %0d got %0d", exp_r.finished, got.finished); n_errors++; end
    if (got.finished_id != exp_r.finished_id) begin
      $error("finished_id exp %0d got %0d", exp_r.finished_id, got.finished_id); n_errors++; end
    if (got.turnaround != exp_r.turnaround) begin
      $error("turnaround exp %0d got %0d", exp_r.turnaround, got.turnaround); n_errors++; end
    if (got.wait_time != exp_r.wait_time) begin
      $error("wait_time exp %0d got %0d", exp_r.wait_time, got.wait_time); n_errors++; end
    if (got.response != exp_r.response) begin
      $error("response exp %0d got %0d", exp_r.response, got.response); n_errors++; end
    if (got.switch_count != exp_r.switch_count) begin
      $error("switch_count exp %0d got %0d", exp_r.switch_count, got.switch_count);
      n_errors++;
    end
    if (got.done_count != exp_r.done_count) begin
      $error("done_count exp %0d got %0d", exp_r.done_count, got.done_count); n_errors++; end
    if (got.now != exp_r.now) begin
      $error("now exp %0d got %0d", exp_r.now, got.now); n_errors++; end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cnt   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) compare_result(out_data_o);
      if (hold_recv) begin
        out_stall_i <= 1'b1;
      end else begin
        if (stall_cnt > 0) stall_cnt--;
        else if (!recv_quiet && $urandom_range(0, 7) == 0)
          stall_cnt = int'($urandom_range(1, 10));
        out_stall_i <= (stall_cnt > 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    // model register updates at the access edge
    if (addr == 3'd0) mode_reg = data[2:0];
    else if (addr == 3'd4) slice_reg = data[7:0];
  endtask

  task automatic drain_all();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic cjs_in_t arrival(logic [7:0] id, logic [7:0] pr, logic [15:0] len);
    cjs_in_t t;
    t.opcode = OP_ARRIVAL; t.job_id = id; t.job_priority = pr; t.job_length = len;
    return t;
  endfunction

  function automatic cjs_in_t tick_item();
    cjs_in_t t;
    t = arrival(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)));
    t.opcode = OP_TICK;
    return t;
  endfunction

  // mostly short jobs so they finish; lengths occasionally large
  task automatic random_phase(int n);
    logic [15:0] len;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: len = 16'd0;
          1: len = 16'($urandom_range(0, 65535));
          default: len = 16'($urandom_range(1, 6));
        endcase
        pending_q = {pending_q, arrival(8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)), len)};
      end else begin
        pending_q = {pending_q, tick_item()};
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  logic [7:0] slices[6] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd4, 8'd3};

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cpu_st = CPU_IDLE; cur_job = '0; tick_no = '0; nswitch = '0; ndone = '0;
    mode_reg = MODE_FCFS; slice_reg = SliceReset; slice_cnt = SliceReset;
    n_errors = 0; n_results = 0; n_finished = 0;
    drive_quiet = 0; recv_quiet = 0; hold_recv = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, zero length, full queue drop, long job
    pending_q = {pending_q, arrival(8'hFF, 8'hFF, 16'hFFFF)};
    pending_q = {pending_q, arrival(8'h00, 8'h00, 16'd0)};
    for (int i = 0; i < 15; i++) pending_q = {pending_q, arrival(8'(i + 1), 8'(i), 16'd1)};
    pending_q = {pending_q, arrival(8'hAA, 8'h55, 16'h5555)}; // dropped: queue full
    for (int i = 0; i < 6; i++) pending_q = {pending_q, tick_item()};

    // Long receiver hold-off while the sender keeps offering
    hold_recv = 1;
    repeat (150) @(posedge clk_i);
    hold_recv = 0;
    drain_all();

    // Sweep modes including unused codes, with quantum extremes
    for (int p = 0; p < 12; p++) begin
      apb_write(3'd0, (p < 10) ? 32'(p % 5) : 32'(5 + p % 3));
      apb_write(3'd4, 32'(slices[p % 6]));
      random_phase(52);
      drain_all(); // sender pauses until all results are in
    end

    // Lone job under round robin with minimal quantum
    apb_write(3'd0, 32'(MODE_RR));
    apb_write(3'd4, 32'd1);
    pending_q = {pending_q, arrival(8'h42, 8'h01, 16'd3)};
    for (int i = 0; i < 10; i++) pending_q = {pending_q, tick_item()};
    drain_all();

    // Final part without idling, also lets the queue empty out
    drive_quiet = 1; recv_quiet = 1;
    apb_write(3'd0, 32'(MODE_SRTF));
    random_phase(60);
    drain_all();

    $display("Covered %0d results (%0d job completions) across all modes and quantum",
             n_results, n_finished);
    $display("settings, with full-queue drops, long output stall and random idle bursts.");
    if (n_errors == 0) begin
      $display("tb_cpu_job_scheduler passed");
    end else begin
      $display("tb_cpu_job_scheduler failed");
    end
    $finish;
  end

endmodule
